FILE: rtl/core/lcd_escape_command_parser_assert.svh
// Assertion macros for the display command parser top level.
`ifndef LCD_ESCAPE_COMMAND_PARSER_ASSERT_SVH
`define LCD_ESCAPE_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LCDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LCDP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lcdp_pkg.sv
// Types, codes and helpers of the display command parser.
package lcdp_pkg;

  localparam int unsigned GlyphBytesDefault = 8;
  localparam int unsigned GlyphRows = 8;

  // Stream byte codes
  localparam logic [7:0] ChEsc    = 8'h1b;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChClear  = 8'h63;  // 'c'
  localparam logic [7:0] ChHome   = 8'h68;  // 'h'
  localparam logic [7:0] ChRaw    = 8'h24;  // '$'
  localparam logic [7:0] ChGlyph  = 8'h67;  // 'g'
  localparam logic [7:0] ChGoto   = 8'h70;  // 'p'
  localparam logic [7:0] ChDrop   = 8'h71;  // 'q'
  localparam logic [7:0] ChBright = 8'h62;  // 'b'
  localparam logic [7:0] ChCursor = 8'h43;  // 'C'
  localparam logic [7:0] ChWind   = 8'h77;  // 'w'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChOne    = 8'h31;  // '1'
  localparam logic [7:0] ChTwo    = 8'h32;  // '2'
  localparam logic [7:0] ChThree  = 8'h33;  // '3'

  typedef enum logic [3:0] {
    ST_DATA       = 4'd0,
    ST_ESC        = 4'd1,
    ST_CMD        = 4'd2,
    ST_GLYPH      = 4'd3,
    ST_GLYPH_DATA = 4'd4,
    ST_GOTO_HI    = 4'd5,
    ST_GOTO_LO    = 4'd6,
    ST_SWALLOW    = 4'd7,
    ST_BRIGHT     = 4'd8,
    ST_CURSOR     = 4'd9,
    ST_WINDMILL   = 4'd10
  } parse_state_e;

  typedef enum logic [3:0] {
    ACT_CHAR     = 4'd0,
    ACT_LINEFEED = 4'd1,
    ACT_CLEAR    = 4'd2,
    ACT_HOME     = 4'd3,
    ACT_RAW      = 4'd4,
    ACT_GLYPH    = 4'd5,
    ACT_GOTO     = 4'd6,
    ACT_BRIGHT   = 4'd7,
    ACT_CURSOR   = 4'd8,
    ACT_WINDMILL = 4'd9,
    ACT_DROP     = 4'd10
  } action_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  operand;
    logic [63:0] glyph_pattern;
  } out_item_t;

  // Decoder result toward the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dec_res_t;

  // Hex digit value, anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h37);
    return v;
  endfunction

endpackage

FILE: rtl/core/lcdp_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface lcdp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lcd_escape_command_parser.sv
// Top level of the display command stream parser.
//
//  channel | dir | payload                              | accepted when
//  in_i    | in  | data_byte[7:0]                       | valid && ready
//  out_o   | out | action[3:0] operand[7:0] glyph[63:0] | valid && ready
//
// One byte per cycle when not stalled: the parser state machine decodes a byte
// in the cycle it is taken; the result register shows any action on the next cycle.
// Reset returns the parser to plain data state and empties the result register.
// A stalled result holds; input stalls only while that result is not taken.
// Glyph rows are not reset; each is written before it is read.
module lcd_escape_command_parser #(
  parameter int unsigned GLYPH_BYTES = lcdp_pkg::GlyphBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcdp_stream_if.sink   in_i,
  lcdp_stream_if.source out_o
);
  import lcdp_pkg::*;

  `include "lcd_escape_command_parser_assert.svh"

  dec_res_t dec_res;
  logic     space;
  logic     in_fire;
  in_item_t in_item;

  assign in_item   = in_i.data;
  assign in_i.ready = space;
  assign in_fire   = in_i.valid && space;

  lcdp_decode #(
    .GLYPH_BYTES(GLYPH_BYTES)
  ) u_decode (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(in_fire),
    .byte_i(in_item.data_byte),
    .res_o (dec_res)
  );

  lcdp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .res_i  (dec_res),
    .space_o(space),
    .out_o  (out_o)
  );

  // Checks
  `LCDP_ASSERT_IMP(a_no_overrun, out_o.valid && !out_o.ready, !in_i.ready, "input taken over a held result")
  `LCDP_ASSERT_IMP(a_pattern_zero, out_o.valid && out_o.data.action != ACT_GLYPH, out_o.data.glyph_pattern == 64'd0, "pattern set on non-glyph action")
  `LCDP_ASSERT_IMP(a_glyph_index, out_o.valid && out_o.data.action == ACT_GLYPH, out_o.data.operand <= 8'd7, "glyph index out of range")
  `LCDP_ASSERT_NXT(a_result_follows, in_fire && dec_res.valid, out_o.valid, "decoded action not shown")

endmodule

FILE: rtl/core/lcdp_decode.sv
// Parser state registers and the per-byte decode logic.
module lcdp_decode #(
  parameter int unsigned GLYPH_BYTES = lcdp_pkg::GlyphBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  output lcdp_pkg::dec_res_t res_o
);
  import lcdp_pkg::*;

  localparam logic [3:0] GlyphCount = 4'(GLYPH_BYTES);

  parse_state_e state_q, state_d;
  logic [2:0]   glyph_idx_q, glyph_idx_d;
  logic [3:0]   row_cnt_q, row_cnt_d;
  logic [7:0]   goto_q, goto_d;
  logic [7:0]   rows_q [GlyphRows];
  logic [3:0]   row_cnt_inc;
  logic [63:0]  pattern;
  logic [7:0]   bright_val;

  assign row_cnt_inc = row_cnt_q + 4'd1;

  // Bright byte: ASCII digit '0' to '3' folds onto raw value
  assign bright_val = (byte_i >= ChZero && byte_i <= ChThree) ? byte_i - ChZero : byte_i;

  // Pattern from stored rows with the current byte in its row
  always_comb begin
    pattern = '0;
    for (int k = 0; k < GlyphRows; k++) begin
      if (k < GLYPH_BYTES) begin
        if (row_cnt_q[2:0] == 3'(k)) pattern[8*k +: 8] = byte_i;
        else                         pattern[8*k +: 8] = rows_q[k];
      end
    end
  end

  // Next state and sequence registers
  always_comb begin
    state_d     = ST_DATA;
    glyph_idx_d = glyph_idx_q;
    row_cnt_d   = row_cnt_q;
    goto_d      = goto_q;
    unique case (state_q)
      ST_ESC: begin
        unique case (byte_i)
          ChRaw:       state_d = ST_CMD;
          ChGlyph:     state_d = ST_GLYPH;
          ChGoto:      state_d = ST_GOTO_HI;
          ChBright:    state_d = ST_BRIGHT;
          ChCursor:    state_d = ST_CURSOR;
          ChWind:      state_d = ST_WINDMILL;
          ChLf, ChCr:  state_d = ST_SWALLOW;
          default:     state_d = ST_DATA;
        endcase
      end
      ST_GLYPH: begin
        if (byte_i <= 8'd7) begin
          glyph_idx_d = byte_i[2:0];
          row_cnt_d   = 4'd0;
          state_d     = ST_GLYPH_DATA;
        end
      end
      ST_GLYPH_DATA: begin
        row_cnt_d = row_cnt_inc;
        if (row_cnt_inc < GlyphCount) state_d = ST_GLYPH_DATA;
      end
      ST_GOTO_HI: begin
        goto_d  = {hex_value(byte_i), 4'd0};
        state_d = ST_GOTO_LO;
      end
      ST_GOTO_LO: goto_d = {goto_q[7:4], hex_value(byte_i)};
      ST_DATA: begin
        if (byte_i == ChEsc) state_d = ST_ESC;
      end
      default: state_d = (byte_i == ChEsc && state_q != ST_CMD && state_q != ST_SWALLOW &&
                          state_q != ST_BRIGHT && state_q != ST_CURSOR &&
                          state_q != ST_WINDMILL) ? ST_ESC : ST_DATA;
    endcase
  end

  // Result of this byte
  always_comb begin
    res_o            = '0;
    res_o.item.action = ACT_CHAR;
    unique case (state_q)
      ST_ESC: begin
        res_o.valid = 1'b1;
        unique case (byte_i)
          ChClear: res_o.item.action = ACT_CLEAR;
          ChHome:  res_o.item.action = ACT_HOME;
          ChDrop:  res_o.item.action = ACT_DROP;
          ChRaw, ChGlyph, ChGoto, ChBright, ChCursor, ChWind, ChLf, ChCr:
            res_o.valid = 1'b0;
          default: res_o.item.operand = byte_i;
        endcase
      end
      ST_CMD: begin
        res_o.valid        = 1'b1;
        res_o.item.action  = ACT_RAW;
        res_o.item.operand = byte_i;
      end
      ST_GLYPH: res_o.valid = 1'b0;
      ST_GLYPH_DATA: begin
        if (row_cnt_inc >= GlyphCount) begin
          res_o.valid              = 1'b1;
          res_o.item.action        = ACT_GLYPH;
          res_o.item.operand       = {5'd0, glyph_idx_q};
          res_o.item.glyph_pattern = pattern;
        end
      end
      ST_GOTO_HI: res_o.valid = 1'b0;
      ST_GOTO_LO: begin
        res_o.valid        = 1'b1;
        res_o.item.action  = ACT_GOTO;
        res_o.item.operand = {goto_q[7:4], hex_value(byte_i)};
      end
      ST_SWALLOW: res_o.valid = 1'b0;
      ST_BRIGHT: begin
        res_o.item.action  = ACT_BRIGHT;
        res_o.item.operand = bright_val;
        res_o.valid        = (bright_val <= 8'd3);
      end
      ST_CURSOR: begin
        res_o.item.action = ACT_CURSOR;
        priority if (byte_i == 8'd0 || byte_i == ChZero) begin
          res_o.valid = 1'b1;
        end else if (byte_i == 8'd1 || byte_i == ChOne) begin
          res_o.valid = 1'b1;  res_o.item.operand = 8'd1;
        end else if (byte_i == 8'd2 || byte_i == ChTwo) begin
          res_o.valid = 1'b1;  res_o.item.operand = 8'd2;
        end
      end
      ST_WINDMILL: begin
        res_o.item.action = ACT_WINDMILL;
        priority if (byte_i == 8'd0 || byte_i == ChZero) begin
          res_o.valid = 1'b1;
        end else if (byte_i == 8'd1 || byte_i == ChOne) begin
          res_o.valid = 1'b1;  res_o.item.operand = 8'd1;
        end
      end
      default: begin
        // plain data, also unused state codes
        res_o.valid = 1'b1;
        priority if (byte_i == ChCr) begin
          res_o.valid = 1'b0;
        end else if (byte_i == ChLf) begin
          res_o.item.action = ACT_LINEFEED;
        end else if (byte_i == ChEsc) begin
          res_o.valid = 1'b0;
        end else begin
          res_o.item.operand = byte_i;
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DATA;
      glyph_idx_q <= 3'd0;
      row_cnt_q   <= 4'd0;
      goto_q      <= 8'd0;
    end else if (fire_i) begin
      state_q     <= state_d;
      glyph_idx_q <= glyph_idx_d;
      row_cnt_q   <= row_cnt_d;
      goto_q      <= goto_d;
    end
  end

  // Glyph row store, written one row per pattern byte
  always_ff @(posedge clk_i) begin
    if (fire_i && state_q == ST_GLYPH_DATA) rows_q[row_cnt_q[2:0]] <= byte_i;
  end

endmodule

FILE: rtl/core/lcdp_out_reg.sv
// Result register toward the output channel.
module lcdp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  lcdp_pkg::dec_res_t res_i,
  output logic               space_o,
  lcdp_stream_if.source      out_o
);
  import lcdp_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // Free when empty or being drained this cycle
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i) begin
      valid_q <= res_i.valid;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_i.valid) item_q <= res_i.item;
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = item_q;

endmodule

FILE: tb/lcd_escape_command_parser_checker.sv
// Checker for the display command parser: predicts each action and compares it with the output.
`timescale 1ns / 100ps

module lcd_escape_command_parser_checker #(
  parameter int unsigned GLYPH_BYTES = lcdp_pkg::GlyphBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lcdp_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lcdp_pkg::out_item_t out_data_i,
  output int                  errors_o,
  output int                  pending_o
);
  import lcdp_pkg::*;

  // Predicted parser state
  parse_state_e parse_q;
  logic [2:0]   glyph_sel;
  logic [7:0]   glyph_row [GlyphRows];
  logic [3:0]   rows_seen;
  logic [7:0]   goto_addr;

  out_item_t    expected_actions [$];
  out_item_t    want;
  out_item_t    predicted;
  bit           produced;
  int           mismatches = 0;

  assign errors_o = mismatches;

  // Hex digit value; anything that is not a hex digit reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return c[3:0];
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  // Advance the predicted parser by one byte; produced tells whether an action results
  function automatic void decode_byte(input logic [7:0] b, output bit produced_o,
                                      output out_item_t res);
    parse_state_e cur;
    cur = parse_q;
    parse_q = ST_DATA;
    produced_o = 1'b0;
    res.action = ACT_CHAR;
    res.operand = b;
    res.glyph_pattern = '0;
    case (cur)
      ST_ESC: begin
        produced_o = 1'b1;
        res.operand = '0;
        case (b)
          ChClear: res.action = ACT_CLEAR;
          ChHome:  res.action = ACT_HOME;
          ChDrop:  res.action = ACT_DROP;
          ChRaw: begin
            parse_q = ST_CMD;
            produced_o = 1'b0;
          end
          ChGlyph: begin
            parse_q = ST_GLYPH;
            produced_o = 1'b0;
          end
          ChGoto: begin
            parse_q = ST_GOTO_HI;
            produced_o = 1'b0;
          end
          ChBright: begin
            parse_q = ST_BRIGHT;
            produced_o = 1'b0;
          end
          ChCursor: begin
            parse_q = ST_CURSOR;
            produced_o = 1'b0;
          end
          ChWind: begin
            parse_q = ST_WINDMILL;
            produced_o = 1'b0;
          end
          ChCr, ChLf: begin
            parse_q = ST_SWALLOW;
            produced_o = 1'b0;
          end
          // unknown escape byte is printed as a character
          default: res.operand = b;
        endcase
      end
      ST_CMD: begin
        produced_o = 1'b1;
        res.action = ACT_RAW;
      end
      ST_GLYPH: begin
        // out-of-range index aborts the sequence quietly
        if (b <= 8'd7) begin
          glyph_sel = b[2:0];
          rows_seen = '0;
          parse_q = ST_GLYPH_DATA;
        end
      end
      ST_GLYPH_DATA: begin
        glyph_row[rows_seen[2:0]] = b;
        rows_seen = rows_seen + 4'd1;
        if (rows_seen < GLYPH_BYTES) begin
          parse_q = ST_GLYPH_DATA;
        end else begin
          produced_o = 1'b1;
          res.action = ACT_GLYPH;
          res.operand = {5'd0, glyph_sel};
          for (int k = 0; k < GlyphRows; k++) begin
            if (k < GLYPH_BYTES) res.glyph_pattern[8*k +: 8] = glyph_row[k];
          end
        end
      end
      ST_GOTO_HI: begin
        goto_addr = {hex_nibble(b), 4'd0};
        parse_q = ST_GOTO_LO;
      end
      ST_GOTO_LO: begin
        goto_addr[3:0] = hex_nibble(b);
        produced_o = 1'b1;
        res.action = ACT_GOTO;
        res.operand = goto_addr;
      end
      ST_SWALLOW: ;
      ST_BRIGHT: begin
        res.action = ACT_BRIGHT;
        if (b <= 8'd3) begin
          produced_o = 1'b1;
        end else if (b inside {[ChZero:ChThree]}) begin
          produced_o = 1'b1;
          res.operand = b - ChZero;
        end
      end
      ST_CURSOR: begin
        res.action = ACT_CURSOR;
        if (b <= 8'd2) begin
          produced_o = 1'b1;
        end else if (b inside {[ChZero:ChTwo]}) begin
          produced_o = 1'b1;
          res.operand = b - ChZero;
        end
      end
      ST_WINDMILL: begin
        res.action = ACT_WINDMILL;
        if (b <= 8'd1) begin
          produced_o = 1'b1;
        end else if (b inside {[ChZero:ChOne]}) begin
          produced_o = 1'b1;
          res.operand = b - ChZero;
        end
      end
      // plain data, unused encodings included
      default: begin
        if (b == ChLf) begin
          produced_o = 1'b1;
          res.action = ACT_LINEFEED;
          res.operand = '0;
        end else if (b == ChEsc) begin
          parse_q = ST_ESC;
        end else if (b != ChCr) begin
          produced_o = 1'b1;
        end
      end
    endcase
  endfunction

  // Compare output transactions first, then predict from the input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q = ST_DATA;
      glyph_sel = '0;
      rows_seen = '0;
      goto_addr = '0;
      for (int k = 0; k < GlyphRows; k++) glyph_row[k] = '0;
      expected_actions.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_actions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected action %0d operand %02h glyph %016h", $realtime,
                     out_data_i.action, out_data_i.operand, out_data_i.glyph_pattern);
          end
        end else begin
          want = expected_actions.pop_front();
          if (out_data_i.action !== want.action || out_data_i.operand !== want.operand ||
              out_data_i.glyph_pattern !== want.glyph_pattern) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected action %0d operand %02h glyph %016h", $realtime,
                       want.action, want.operand, want.glyph_pattern);
              $display("%0t:      got action %0d operand %02h glyph %016h", $realtime,
                       out_data_i.action, out_data_i.operand, out_data_i.glyph_pattern);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_data_i.data_byte, produced, predicted);
        if (produced) expected_actions.push_back(predicted);
      end
      pending_o <= expected_actions.size();
    end
  end

endmodule

FILE: tb/lcd_escape_command_parser_tb.sv
// Testbench top for the display command parser: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module lcd_escape_command_parser_tb;
  import lcdp_pkg::*;

  localparam int unsigned GLYPH_BYTES = lcdp_pkg::GlyphBytesDefault;
  localparam int          STREAM_BYTES = 500;
  localparam int          IDLE_LIMIT = 1000;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcdp_stream_if #(.payload_t(in_item_t))  in_ch ();
  lcdp_stream_if #(.payload_t(out_item_t)) out_ch ();

  int mismatch_total;
  int actions_owed;
  int useful_bytes = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  lcd_escape_command_parser #(
    .GLYPH_BYTES(GLYPH_BYTES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  lcd_escape_command_parser_checker #(
    .GLYPH_BYTES(GLYPH_BYTES)
  ) checker_inst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_i (in_ch.ready),
    .in_data_i  (in_ch.data),
    .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_data_i (out_ch.data),
    .errors_o   (mismatch_total),
    .pending_o  (actions_owed)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Hex digit in either case, or now and then any byte
  function automatic logic [7:0] goto_digit();
    int v;
    v = $urandom_range(0, 25);
    if (v < 10) return ChZero + 8'(v);
    if (v < 16) return 8'h61 + 8'(v - 10);
    if (v < 22) return 8'h41 + 8'(v - 16);
    return 8'($urandom_range(0, 255));
  endfunction

  // Sink side: random back-pressure on the result channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!sink_steady) stall_left = pick_gap();
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // One input transaction, with an optional gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    useful_bytes++;
  endtask

  // Hold the input off until every predicted action has come out
  task automatic wait_for_actions();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (actions_owed != 0);
  endtask

  // One random command sequence, mostly well formed
  task automatic send_sequence();
    int kind;
    int v;
    logic [7:0] arg;
    kind = $urandom_range(0, 19);
    arg = 8'($urandom_range(0, 255));
    case (kind)
      0, 1, 2, 19: send_byte(arg);
      3: send_byte(ChLf);
      4: begin
        // a lone CR is dropped by the parser
        send_byte(ChCr);
        useful_bytes--;
      end
      5, 6, 7: begin
        send_byte(ChEsc);
        send_byte(kind == 5 ? ChClear : (kind == 6 ? ChHome : ChDrop));
      end
      8: begin
        send_byte(ChEsc);
        send_byte(ChRaw);
        send_byte(arg);
      end
      9, 10: begin
        send_byte(ChEsc);
        send_byte(ChGlyph);
        arg = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8, 255))
                                          : 8'($urandom_range(0, 7));
        send_byte(arg);
        if (arg <= 8'd7) begin
          repeat (GLYPH_BYTES) send_byte(8'($urandom_range(0, 255)));
        end
      end
      11, 12: begin
        send_byte(ChEsc);
        send_byte(ChGoto);
        send_byte(goto_digit());
        send_byte(goto_digit());
      end
      13: begin
        v = $urandom_range(0, 9);
        if (v < 4) arg = 8'(v);
        else if (v < 8) arg = ChZero + 8'(v - 4);
        send_byte(ChEsc);
        send_byte(ChBright);
        send_byte(arg);
      end
      14: begin
        v = $urandom_range(0, 9);
        if (v < 3) arg = 8'(v);
        else if (v < 6) arg = ChZero + 8'(v - 3);
        send_byte(ChEsc);
        send_byte(ChCursor);
        send_byte(arg);
      end
      15: begin
        v = $urandom_range(0, 6);
        if (v < 2) arg = 8'(v);
        else if (v < 4) arg = ChZero + 8'(v - 2);
        send_byte(ChEsc);
        send_byte(ChWind);
        send_byte(arg);
      end
      16: begin
        // escaped line break swallows the following byte
        send_byte(ChEsc);
        send_byte($urandom_range(0, 1) ? ChCr : ChLf);
        send_byte(arg);
      end
      17: begin
        send_byte(ChEsc);
        send_byte(arg);
      end
      default: begin
        // truncated sequence, the next one gets eaten as its argument
        v = $urandom_range(0, 5);
        send_byte(ChEsc);
        case (v)
          0: send_byte(ChRaw);
          1: send_byte(ChGlyph);
          2: send_byte(ChGoto);
          3: send_byte(ChBright);
          4: send_byte(ChCursor);
          default: send_byte(ChWind);
        endcase
      end
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    logic [7:0] opening [$];
    int next_phase;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_ni = 1'b0;
    opening = '{8'h00, ChCr, ChLf, 8'hFF,
                ChEsc, ChClear, ChEsc, ChHome, ChEsc, ChDrop,
                ChEsc, ChRaw, 8'h80, ChEsc, 8'h7A,
                ChEsc, ChGlyph, 8'h07,
                8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7E, 8'hC3,
                ChEsc, ChGoto, 8'h46, 8'h7A};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening
    foreach (opening[i]) send_byte(opening[i]);
    wait_for_actions();

    // Random phases with changing flow control
    useful_bytes = 0;
    next_phase = 100;
    while (useful_bytes < STREAM_BYTES) begin
      if (useful_bytes >= next_phase) begin
        next_phase += 100;
        if ($urandom_range(0, 1)) wait_for_actions();
        src_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      send_sequence();
    end

    wait_for_actions();
    repeat (4) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
